// ===== rtl/wsg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsg_pkg
// Shared types and constants of the waveform signal generator.
// ----------------------------------------------------------------------------
package wsg_pkg;

    localparam int PHASE_W    = 32;
    localparam int TIME_W     = 16;
    localparam int AMP_W      = 16;
    localparam int OUT_W      = 16;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FREQUENCY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS         = 3'd4;

    // wave modes
    localparam logic [MODE_W-1:0] MODE_CONST  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SINE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COSINE = 2'd2;

    localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;

    // phase queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // table generation constants (Q30)
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;
    localparam logic [63:0] TAYLOR_DIV [8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    localparam logic signed [17:0] SAT_MAX = 18'sd32767;
    localparam logic signed [17:0] SAT_MIN = -18'sd32768;

    typedef struct packed {
        logic [MODE_W-1:0]     wave_mode;
        logic signed [AMP_W-1:0] amplitude_value;
        logic [PHASE_W-1:0]    frequency_word;
        logic [PHASE_W-1:0]    phase_offset;
        logic signed [AMP_W-1:0] bias_value;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic [PHASE_W-1:0] phase;
    } q_push_t;

    typedef struct packed {
        logic [QCNT_W-1:0]  count;
        logic               not_empty;
        logic [PHASE_W-1:0] phase;
    } q_stat_t;

endpackage
`default_nettype wire

// ===== rtl/wsg_tick_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsg_tick_if
// Tick channel: one request carries the elapsed time step.
// ----------------------------------------------------------------------------
interface wsg_tick_if;
    logic        valid;
    logic        ready;
    logic [15:0] time_step;

    modport source (output valid, output time_step, input ready);
    modport sink   (input valid, input time_step, output ready);
endinterface
`default_nettype wire

// ===== rtl/wsg_sample_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsg_sample_if
// Sample channel: one request carries one generated sample.
// ----------------------------------------------------------------------------
interface wsg_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface
`default_nettype wire

// ===== rtl/wsg_cfg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsg_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface wsg_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/wsg_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsg_cfg_regs
// Configuration register file, written through the config channel.
// ----------------------------------------------------------------------------
module wsg_cfg_regs
    import wsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    wsg_cfg_if.sink     cfg,
    output cfg_t        cfg_val
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_val   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_WAVE_MODE:    cfg_next.wave_mode       = cfg.data[MODE_W-1:0];
                REG_AMPLITUDE:    cfg_next.amplitude_value = cfg.data[AMP_W-1:0];
                REG_FREQUENCY:    cfg_next.frequency_word  = cfg.data[PHASE_W-1:0];
                REG_PHASE_OFFSET: cfg_next.phase_offset    = cfg.data[PHASE_W-1:0];
                REG_BIAS:         cfg_next.bias_value      = cfg.data[AMP_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/wsg_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsg_front
// Accepts ticks, forms step * frequency and advances the phase accumulator.
// ----------------------------------------------------------------------------
module wsg_front
    import wsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    wsg_tick_if.sink    tick,
    input  cfg_t        cfg_val,
    input  q_stat_t     q_stat,
    output q_push_t     q_push
);

    logic [PHASE_W-1:0] prod_reg;
    logic [PHASE_W-1:0] prod_next;
    logic               pv_reg;
    logic               pv_next;
    logic [PHASE_W-1:0] accum_reg;
    logic [PHASE_W-1:0] accum_next;
    logic [QCNT_W-1:0]  reserved;
    logic [TIME_W+PHASE_W-1:0] full_prod;
    logic               accept;

    // a product in flight already owns a queue slot
    assign reserved  = q_stat.count + QCNT_W'(pv_reg);
    assign tick.ready = (reserved < QCNT_W'(QUEUE_DEPTH));
    assign accept    = tick.valid && tick.ready;

    assign full_prod = (TIME_W+PHASE_W)'(tick.time_step) *
                       (TIME_W+PHASE_W)'(cfg_val.frequency_word);

    always_comb
    begin
        prod_next  = accept ? full_prod[PHASE_W-1:0] : prod_reg;
        pv_next    = accept;
        accum_next = pv_reg ? (accum_reg + prod_reg) : accum_reg;
    end

    assign q_push.valid = pv_reg;
    assign q_push.phase = accum_reg + prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg    <= 1'b0;
            accum_reg <= '0;
        end
        else
        begin
            pv_reg    <= pv_next;
            accum_reg <= accum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule
`default_nettype wire

// ===== rtl/wsg_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsg_queue
// Short phase queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module wsg_queue
    import wsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_push_t     q_push,
    input  logic        pop,
    output q_stat_t     q_stat
);

    logic [PHASE_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = q_push.valid ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(q_push.valid) - QCNT_W'(do_pop);
    end

    assign q_stat.count     = count_reg;
    assign q_stat.not_empty = (count_reg != '0);
    assign q_stat.phase     = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push.valid)
        begin
            entry_reg[wr_ptr_reg] <= q_push.phase;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/wsg_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsg_back
// Phase to sample: offset, quarter-wave lookup, amplitude scaling, bias
// and saturation. The whole pipeline holds while the output is stalled.
// ----------------------------------------------------------------------------
module wsg_back
    import wsg_pkg::*;
#(
    parameter int TABLE_DEPTH  = 1024,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg_val,
    input  q_stat_t     q_stat,
    output logic        pop,
    wsg_sample_if.source sample
);

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int MAG_W   = SAMPLE_WIDTH - 1;
    localparam int KMUL_W  = 30 + ADDR_W;
    localparam int PROD_W  = 17 + MAG_W;
    localparam logic [63:0] TAB_DIV = 64'(4 * TABLE_DEPTH);

    typedef logic [MAG_W-1:0] tab_t [TABLE_DEPTH];

    // quarter-wave sine, sampled at the bin centers
    function automatic tab_t build_tab();
        tab_t        t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] maxv;
        maxv = (64'd1 << MAG_W) - 64'd1;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            x    = (64'(2 * k + 1) * PI_Q30) / TAB_DIV;
            x2   = (x * x + (ONE_Q30 >> 1)) >> 30;
            term = x;
            sum  = x;
            for (int n = 1; n <= 8; n++)
            begin
                term = (term * x2) / TAYLOR_DIV[n-1];
                term = term >> 30;
                if ((n % 2) == 1)
                begin
                    sum = (term > sum) ? 64'd0 : (sum - term);
                end
                else
                begin
                    sum = sum + term;
                end
            end
            if (sum > ONE_Q30)
            begin
                sum = ONE_Q30;
            end
            t[k] = MAG_W'((sum * maxv + (ONE_Q30 >> 1)) >> 30);
        end
        return t;
    endfunction

    localparam tab_t SINE_TAB = build_tab();

    logic                  en;

    // stage 1: phase
    logic                  v1_reg;
    logic [PHASE_W-1:0]    p_reg;
    // stage 2: table address
    logic                  v2_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic                  neg2_reg;
    // stage 3: magnitude
    logic                  v3_reg;
    logic [MAG_W-1:0]      mag_reg;
    logic                  neg3_reg;
    // stage 4: scaled product
    logic                  v4_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic                  neg4_reg;
    // output
    logic                  out_valid_reg;
    logic signed [OUT_W-1:0] sample_reg;

    logic [PHASE_W-1:0]    p_next;
    logic [KMUL_W-1:0]     kprod;
    logic [ADDR_W-1:0]     k;
    logic [ADDR_W-1:0]     addr_next;
    logic [AMP_W-1:0]      amp_u;
    logic [AMP_W-1:0]      amag;
    logic [PROD_W-1:0]     prod_next;
    logic [16:0]           scaled;
    logic signed [17:0]    sval;
    logic signed [17:0]    total;
    logic signed [OUT_W-1:0] sat;
    logic signed [OUT_W-1:0] sample_next;

    assign en  = !out_valid_reg || sample.ready;
    assign pop = en && q_stat.not_empty;

    always_comb
    begin
        p_next = q_stat.phase + cfg_val.phase_offset;
        if (cfg_val.wave_mode == MODE_COSINE)
        begin
            p_next = p_next + QUARTER_TURN;
        end
    end

    assign kprod     = KMUL_W'(p_reg[29:0]) * KMUL_W'(TABLE_DEPTH);
    assign k         = kprod[KMUL_W-1:30];
    assign addr_next = p_reg[30] ? (ADDR_W'(TABLE_DEPTH - 1) - k) : k;

    assign amp_u     = cfg_val.amplitude_value;
    assign amag      = amp_u[AMP_W-1] ? (~amp_u + 1'b1) : amp_u;
    assign prod_next = PROD_W'(amag) * PROD_W'(mag_reg) + (PROD_W'(1) << (MAG_W - 1));

    always_comb
    begin
        scaled = prod_reg[PROD_W-1:MAG_W];
        sval   = neg4_reg ? -$signed({1'b0, scaled}) : $signed({1'b0, scaled});
        total  = sval + 18'(cfg_val.bias_value);
        if (total > SAT_MAX)
        begin
            sat = OUT_W'(SAT_MAX);
        end
        else if (total < SAT_MIN)
        begin
            sat = OUT_W'(SAT_MIN);
        end
        else
        begin
            sat = total[OUT_W-1:0];
        end

        case (cfg_val.wave_mode)
            MODE_CONST:  sample_next = cfg_val.amplitude_value;
            MODE_SINE:   sample_next = sat;
            MODE_COSINE: sample_next = sat;
            default:     sample_next = '0;
        endcase
    end

    assign sample.valid      = out_valid_reg;
    assign sample.sample_out = sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= q_stat.not_empty;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg      <= p_next;
            addr_reg   <= addr_next;
            neg2_reg   <= p_reg[31];
            mag_reg    <= SINE_TAB[addr_reg];
            neg3_reg   <= neg2_reg;
            prod_reg   <= prod_next;
            neg4_reg   <= neg3_reg ^ amp_u[AMP_W-1];
            sample_reg <= sample_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/waveform_signal_generator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// waveform_signal_generator_top
// Tick-driven sine / cosine / constant source built on a phase accumulator.
// ----------------------------------------------------------------------------
//  channel   role    payload                         request
//  tick      sink    time_step [15:0]                valid & ready
//  sample    source  sample_out [15:0] signed        valid & ready
//  cfg       sink    index [2:0], data [31:0]        valid & ready (ready = 1)
//
//  One tick per cycle sustained while the sample sink keeps taking samples.
//  The rate is set by the accumulator add in the front, one per cycle.
//  The sine table is constant logic, so there is no fill pass after reset.
//  A stalled sample holds the back pipeline; the four-entry phase queue
//  keeps taking ticks until it is full.
// ----------------------------------------------------------------------------
module waveform_signal_generator_top
    import wsg_pkg::*;
#(
    parameter int TABLE_DEPTH  = 1024,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    wsg_tick_if.sink     tick,
    wsg_sample_if.source sample,
    wsg_cfg_if.sink      cfg
);

    cfg_t    cfg_val;
    q_push_t q_push;
    q_stat_t q_stat;
    logic    pop;

    wsg_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    wsg_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick),
        .cfg_val (cfg_val),
        .q_stat  (q_stat),
        .q_push  (q_push)
    );

    wsg_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .pop     (pop),
        .q_stat  (q_stat)
    );

    wsg_back #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_val (cfg_val),
        .q_stat  (q_stat),
        .pop     (pop),
        .sample  (sample)
    );

endmodule
`default_nettype wire

// ===== tb/sv/waveform_signal_generator_top_tb.sv =====
// ----------------------------------------------------------------------------
// waveform_signal_generator_top_tb
// Streams time-step ticks into the generator under random source gaps and
// sink stalls, predicts every sample with a fixed-point phase accumulator and
// quarter-wave table model, and checks each sample in order. Configuration
// is rewritten between bursts, once the pipeline has drained.
// ----------------------------------------------------------------------------
module waveform_signal_generator_top_tb
    import wsg_pkg::*;
();

    localparam int          TABLE_SIZE     = 1024;
    localparam bit [63:0]   PI_FIXED       = 64'd3373259426;
    localparam bit [63:0]   UNITY_Q30      = 64'd1 << 30;
    localparam bit [63:0]   SAMPLE_MAX     = 64'd32767;
    localparam logic [MODE_W-1:0]    MODE_UNUSED     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;
    localparam int          RANDOM_TICKS   = 1250;
    localparam int          HOLD_CYCLES    = 150;
    localparam int          SETTLE_CYCLES  = 10;
    localparam int          WATCHDOG_LIMIT = 2000;

    logic clk;
    logic rst_n;

    wsg_tick_if   tick_ch ();
    wsg_sample_if sample_ch ();
    wsg_cfg_if    cfg_ch ();

    waveform_signal_generator_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .sample (sample_ch),
        .cfg    (cfg_ch)
    );

    // model state
    bit [15:0]                sine_table [TABLE_SIZE];
    logic [MODE_W-1:0]        cfg_mode   = MODE_CONST;
    logic signed [AMP_W-1:0]  cfg_amp    = '0;
    logic [PHASE_W-1:0]       cfg_freq   = '0;
    logic [PHASE_W-1:0]       cfg_offset = '0;
    logic signed [AMP_W-1:0]  cfg_bias   = '0;
    logic [PHASE_W-1:0]       phase_acc  = '0;

    logic [TIME_W-1:0]        tick_backlog [$];
    logic signed [OUT_W-1:0]  predicted_samples [$];

    int          failures       = 0;
    bit          tick_gaps_on   = 1'b1;
    bit          sink_stalls_on = 1'b1;
    bit          hold_request   = 1'b0;
    bit          hold_taken     = 1'b0;
    int unsigned hold_left      = 0;
    int unsigned stall_left     = 0;
    int unsigned tick_gap       = 0;
    int unsigned sink_pause;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // quarter-wave table: Taylor series in Q30 radians at bin centers
    initial
    begin
        int        k;
        int        n;
        bit [63:0] x;
        bit [63:0] x2;
        bit [63:0] term;
        bit [63:0] sum;
        for (k = 0; k < TABLE_SIZE; k++)
        begin
            x    = (64'(2 * k + 1) * PI_FIXED) / (64'd4 * TABLE_SIZE);
            x2   = (x * x + (UNITY_Q30 >> 1)) >> 30;
            term = x;
            sum  = x;
            for (n = 1; n <= 8; n++)
            begin
                term = (term * x2 / (64'(2 * n) * 64'(2 * n + 1))) >> 30;
                if (n % 2 == 1)
                    sum = (term > sum) ? 64'd0 : sum - term;
                else
                    sum = sum + term;
            end
            if (sum > UNITY_Q30)
                sum = UNITY_Q30;
            sine_table[k] = 16'((sum * SAMPLE_MAX + (UNITY_Q30 >> 1)) >> 30);
        end
    end

    function automatic logic signed [OUT_W-1:0] scaled_wave(input logic [PHASE_W-1:0] p);
        logic [1:0] quad;
        int         idx;
        int         a;
        bit [63:0]  mag;
        bit [63:0]  amag;
        bit [63:0]  prod;
        logic       neg;
        int         v;
        quad = p[31:30];
        idx  = int'((64'(p[29:0]) * TABLE_SIZE) >> 30);
        if (quad[0])
            idx = TABLE_SIZE - 1 - idx;
        mag  = 64'(sine_table[idx]);
        a    = cfg_amp;
        neg  = quad[1] ^ (a < 0);
        amag = (a < 0) ? 64'(-a) : 64'(a);
        prod = (amag * mag + 64'd16384) >> 15;
        v    = neg ? -int'(prod) : int'(prod);
        v    = v + cfg_bias;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    // one tick: advance the accumulator in every mode, then form the sample
    function automatic logic signed [OUT_W-1:0] next_sample(input logic [TIME_W-1:0] dt);
        logic [PHASE_W-1:0] p;
        phase_acc = phase_acc + dt * cfg_freq;
        p = phase_acc + cfg_offset;
        case (cfg_mode)
            MODE_CONST:  return cfg_amp;
            MODE_SINE:   return scaled_wave(p);
            MODE_COSINE: return scaled_wave(p + QUARTER_TURN);
            default:     return '0;
        endcase
    endfunction

    function automatic int unsigned draw_idle(input bit enabled);
        if (!enabled || $urandom_range(0, 3) != 0)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(15, 60);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic signed [AMP_W-1:0] pick_q15();
        case ($urandom_range(0, 7))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return '0;
            3:       return -16'sd1;
            4:       return 16'sd1;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [PHASE_W-1:0] pick_turns();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'd1;
            3:       return 32'h8000_0000;
            4,
            5:       return $urandom_range(0, 32'h0010_0000);
            default: return $urandom();
        endcase
    endfunction

    function automatic void queue_tick(input logic [TIME_W-1:0] step);
        tick_backlog.push_back(step);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_WAVE_MODE:    cfg_mode   = value[MODE_W-1:0];
            REG_AMPLITUDE:    cfg_amp    = value[AMP_W-1:0];
            REG_FREQUENCY:    cfg_freq   = value;
            REG_PHASE_OFFSET: cfg_offset = value;
            REG_BIAS:         cfg_bias   = value[AMP_W-1:0];
            default:          ;
        endcase
    endtask

    // random rewrite of a subset of registers, upper data bits filled with noise
    task automatic reprogram();
        logic [CFG_DATA_W-1:0] value;
        int                    r;
        if ($urandom_range(0, 1))
        begin
            r = $urandom_range(0, 15);
            value = $urandom();
            value[MODE_W-1:0] = (r == 0) ? MODE_UNUSED : (r < 4) ? MODE_CONST :
                                (r < 10) ? MODE_SINE : MODE_COSINE;
            write_reg(REG_WAVE_MODE, value);
        end
        if ($urandom_range(0, 1))
        begin
            value = $urandom();
            value[AMP_W-1:0] = pick_q15();
            write_reg(REG_AMPLITUDE, value);
        end
        if ($urandom_range(0, 1))
            write_reg(REG_FREQUENCY, pick_turns());
        if ($urandom_range(0, 1))
            write_reg(REG_PHASE_OFFSET, pick_turns());
        if ($urandom_range(0, 1))
        begin
            value = $urandom();
            value[AMP_W-1:0] = pick_q15();
            write_reg(REG_BIAS, value);
        end
        if ($urandom_range(0, 7) == 0)
            write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom());
    endtask

    task automatic drain();
        while (tick_backlog.size() != 0 || tick_ch.valid || predicted_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // tick source
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tick_ch.valid && tick_ch.ready)
                predicted_samples.push_back(next_sample(tick_ch.time_step));
            if (!tick_ch.valid || tick_ch.ready)
            begin
                if (tick_gap > 0)
                begin
                    tick_gap      <= tick_gap - 1;
                    tick_ch.valid <= 1'b0;
                end
                else if (tick_backlog.size() != 0)
                begin
                    tick_ch.valid     <= 1'b1;
                    tick_ch.time_step <= tick_backlog.pop_front();
                    tick_gap          <= draw_idle(tick_gaps_on);
                end
                else
                    tick_ch.valid <= 1'b0;
            end
        end
    end

    // sample sink and checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                if (predicted_samples.size() == 0)
                begin
                    $display("%0t: sample with none expected: expected none, actual %0d",
                             $time, sample_ch.sample_out);
                    failures++;
                end
                else
                begin
                    if (sample_ch.sample_out !== predicted_samples[0])
                    begin
                        $display("%0t: sample mismatch: expected %0d, actual %0d",
                                 $time, predicted_samples[0], sample_ch.sample_out);
                        failures++;
                    end
                    void'(predicted_samples.pop_front());
                end
            end
            if (hold_request && !hold_taken)
            begin
                hold_taken      <= 1'b1;
                hold_left       <= HOLD_CYCLES - 1;
                sample_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left       <= hold_left - 1;
                sample_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left      <= stall_left - 1;
                sample_ch.ready <= 1'b0;
            end
            else
            begin
                sink_pause = draw_idle(sink_stalls_on);
                if (sink_pause > 0)
                begin
                    stall_left      <= sink_pause - 1;
                    sample_ch.ready <= 1'b0;
                end
                else
                    sample_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog: cycles without any request on any channel
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((tick_ch.valid && tick_ch.ready) || (sample_ch.valid && sample_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int          n;
        int          r;
        int unsigned random_left;
        bit          first_phase;
        rst_n             = 1'b0;
        tick_ch.valid     = 1'b0;
        tick_ch.time_step = '0;
        sample_ch.ready   = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // reset config: constant mode, zero amplitude
        @(negedge clk);
        queue_tick(16'd0);
        queue_tick(16'hFFFF);
        drain();

        // constant mode ignores the bias
        write_reg(REG_WAVE_MODE, 32'(MODE_CONST));
        write_reg(REG_AMPLITUDE, 32'h0000_8000);
        write_reg(REG_BIAS, 32'h0000_7FFF);
        @(negedge clk);
        queue_tick(16'd1);
        queue_tick(16'hFFFF);
        drain();

        // eighth-turn steps walk every quadrant and wrap the accumulator
        write_reg(REG_WAVE_MODE, 32'(MODE_SINE));
        write_reg(REG_AMPLITUDE, 32'h0000_7FFF);
        write_reg(REG_BIAS, 32'h0);
        write_reg(REG_FREQUENCY, 32'h2000_0000);
        @(negedge clk);
        for (n = 0; n < 8; n++)
            queue_tick(16'd1);
        drain();

        // cosine with extreme amplitude, bias and phase
        write_reg(REG_WAVE_MODE, 32'(MODE_COSINE));
        write_reg(REG_AMPLITUDE, 32'h0000_8000);
        write_reg(REG_FREQUENCY, 32'hFFFF_FFFF);
        write_reg(REG_PHASE_OFFSET, 32'hFFFF_FFFF);
        write_reg(REG_BIAS, 32'h0000_7FFF);
        @(negedge clk);
        queue_tick(16'hFFFF);
        queue_tick(16'h8000);
        queue_tick(16'd1);
        drain();

        // negative peak plus most negative bias: saturates low
        write_reg(REG_WAVE_MODE, 32'(MODE_SINE));
        write_reg(REG_AMPLITUDE, 32'h0000_7FFF);
        write_reg(REG_FREQUENCY, 32'h0);
        write_reg(REG_PHASE_OFFSET, 32'hC000_0000);
        write_reg(REG_BIAS, 32'h0000_8000);
        @(negedge clk);
        queue_tick(16'd0);
        drain();

        // unused mode gives zero; writes to spare indexes change nothing
        write_reg(REG_WAVE_MODE, 32'(MODE_UNUSED));
        write_reg(REG_AMPLITUDE, 32'h0000_1234);
        write_reg(REG_FREQUENCY, 32'h0123_4567);
        write_reg(REG_SPARE_FIRST, $urandom());
        write_reg(REG_SPARE_LAST, $urandom());
        @(negedge clk);
        queue_tick(16'd5);
        queue_tick(16'd7);
        drain();

        random_left = RANDOM_TICKS;
        first_phase = 1'b1;
        while (random_left > 0)
        begin
            reprogram();
            @(negedge clk);
            if (first_phase)
            begin
                // long sink hold while ticks keep coming: fills the phase queue
                n              = 40;
                tick_gaps_on   = 1'b0;
                sink_stalls_on = 1'b0;
                hold_request   = 1'b1;
                first_phase    = 1'b0;
            end
            else
            begin
                n              = $urandom_range(10, 80);
                tick_gaps_on   = ($urandom_range(0, 3) != 0);
                sink_stalls_on = ($urandom_range(0, 3) != 0);
            end
            if (n > random_left)
                n = random_left;
            random_left = random_left - n;
            repeat (n)
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    queue_tick(16'd0);
                else if (r == 1)
                    queue_tick(16'hFFFF);
                else if (r < 5)
                    queue_tick(TIME_W'($urandom_range(1, 64)));
                else
                    queue_tick(TIME_W'($urandom()));
            end
            drain();
        end

        if (failures == 0 && predicted_samples.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
